[rtl/iiws_pkg.sv]
package iiws_pkg;

    localparam int PIX_W = 16;
    localparam int SQ_PIX_W = 31;
    localparam int SUM_W = 38;
    localparam int SUM_SQ_W = 53;
    localparam int LINE_W = SUM_W + SUM_SQ_W;
    localparam int CFG_W = 12;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET = 12'd2048;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 12'd2048;

    typedef struct packed {
        logic row_start;
        logic row_first;
        logic row_end;
        logic frame_end;
    } scan_flags_t;

endpackage

[rtl/iiws_ram.sv]
module iiws_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/iiws_scan.sv]
module iiws_scan #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [iiws_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [iiws_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                              advance,
    output logic [$clog2(MAX_WIDTH)-1:0]      col,
    output iiws_pkg::scan_flags_t             flags
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    logic [iiws_pkg::CFG_W-1:0] frame_width_reg;
    logic [iiws_pkg::CFG_W-1:0] frame_height_reg;
    logic [COL_W-1:0]           col_reg;
    logic [COL_W-1:0]           col_next;
    logic [ROW_W-1:0]           row_reg;
    logic [ROW_W-1:0]           row_next;
    logic [31:0]                width_eff;
    logic [31:0]                height_eff;
    logic                       last_col;
    logic                       last_row;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg <= iiws_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= iiws_pkg::FRAME_HEIGHT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                iiws_pkg::REG_FRAME_WIDTH: frame_width_reg <= cfg_wdata;
                iiws_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (frame_width_reg == '0) begin
            width_eff = 32'd1;
        end else if (32'(frame_width_reg) > 32'(MAX_WIDTH)) begin
            width_eff = 32'(MAX_WIDTH);
        end else begin
            width_eff = 32'(frame_width_reg);
        end
        if (frame_height_reg == '0) begin
            height_eff = 32'd1;
        end else if (32'(frame_height_reg) > 32'(MAX_HEIGHT)) begin
            height_eff = 32'(MAX_HEIGHT);
        end else begin
            height_eff = 32'(frame_height_reg);
        end
        last_col = (32'(col_reg) + 32'd1) >= width_eff;
        last_row = (32'(row_reg) + 32'd1) >= height_eff;
        if (last_col) begin
            col_next = '0;
            row_next = last_row ? '0 : ROW_W'(32'(row_reg) + 32'd1);
        end else begin
            col_next = COL_W'(32'(col_reg) + 32'd1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (advance) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col = col_reg;
    assign flags.row_start = (col_reg == '0);
    assign flags.row_first = (row_reg == '0);
    assign flags.row_end = last_col;
    assign flags.frame_end = last_col && last_row;

endmodule

[rtl/iiws_accum.sv]
module iiws_accum #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_accept,
    input  logic signed [iiws_pkg::PIX_W-1:0]      in_pixel,
    input  logic [$clog2(MAX_WIDTH)-1:0]           in_col,
    input  iiws_pkg::scan_flags_t                  in_flags,
    output logic                                   in_ready,
    input  logic [iiws_pkg::LINE_W-1:0]            rd_data,
    output logic                                   wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0]           wr_addr,
    output logic [iiws_pkg::LINE_W-1:0]            wr_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [iiws_pkg::SUM_W-1:0]      m_area_sum,
    output logic [iiws_pkg::SUM_SQ_W-1:0]          m_area_sum_sq,
    output logic                                   m_row_end,
    output logic                                   m_frame_end
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int RT_W = iiws_pkg::PIX_W + COL_W;
    localparam int RT_SQ_W = iiws_pkg::SQ_PIX_W + COL_W;

    logic                                 s1_valid_reg;
    logic signed [iiws_pkg::PIX_W-1:0]    s1_pixel_reg;
    logic [iiws_pkg::SQ_PIX_W-1:0]        s1_sq_reg;
    logic [COL_W-1:0]                     s1_col_reg;
    iiws_pkg::scan_flags_t                s1_flags_reg;
    logic                                 s1_fwd_reg;
    logic [iiws_pkg::LINE_W-1:0]          s1_fwd_data_reg;
    logic signed [RT_W-1:0]               row_total_reg;
    logic [RT_SQ_W-1:0]                   row_total_sq_reg;
    logic                                 m_valid_reg;
    logic signed [iiws_pkg::SUM_W-1:0]    m_area_sum_reg;
    logic [iiws_pkg::SUM_SQ_W-1:0]        m_area_sum_sq_reg;
    logic                                 m_row_end_reg;
    logic                                 m_frame_end_reg;

    logic signed [31:0]                   pixel_prod;
    logic                                 s1_adv;
    logic [iiws_pkg::LINE_W-1:0]          above_line;
    logic signed [iiws_pkg::SUM_W-1:0]    above_sum;
    logic [iiws_pkg::SUM_SQ_W-1:0]        above_sum_sq;
    logic signed [RT_W-1:0]               row_total_next;
    logic [RT_SQ_W-1:0]                   row_total_sq_next;
    logic signed [iiws_pkg::SUM_W-1:0]    area_sum;
    logic [iiws_pkg::SUM_SQ_W-1:0]        area_sum_sq;

    assign pixel_prod = in_pixel * in_pixel;
    assign s1_adv = s1_valid_reg && (!m_valid_reg || m_ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    // A write that lands on the column being read in the same cycle is bypassed.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_pixel_reg <= in_pixel;
            s1_sq_reg <= pixel_prod[iiws_pkg::SQ_PIX_W-1:0];
            s1_col_reg <= in_col;
            s1_flags_reg <= in_flags;
            s1_fwd_reg <= wr_en && (wr_addr == in_col);
            s1_fwd_data_reg <= wr_data;
        end
    end

    always_comb begin
        if (s1_flags_reg.row_first) begin
            above_line = '0;
        end else if (s1_fwd_reg) begin
            above_line = s1_fwd_data_reg;
        end else begin
            above_line = rd_data;
        end
        above_sum = above_line[iiws_pkg::LINE_W-1:iiws_pkg::SUM_SQ_W];
        above_sum_sq = above_line[iiws_pkg::SUM_SQ_W-1:0];
        if (s1_flags_reg.row_start) begin
            row_total_next = RT_W'(s1_pixel_reg);
            row_total_sq_next = RT_SQ_W'(s1_sq_reg);
        end else begin
            row_total_next = row_total_reg + RT_W'(s1_pixel_reg);
            row_total_sq_next = row_total_sq_reg + RT_SQ_W'(s1_sq_reg);
        end
        area_sum = above_sum + iiws_pkg::SUM_W'(row_total_next);
        area_sum_sq = above_sum_sq + iiws_pkg::SUM_SQ_W'(row_total_sq_next);
    end

    assign wr_en = s1_adv;
    assign wr_addr = s1_col_reg;
    assign wr_data = {area_sum, area_sum_sq};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            row_total_reg <= '0;
            row_total_sq_reg <= '0;
        end else begin
            if (in_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                m_valid_reg <= 1'b1;
                row_total_reg <= row_total_next;
                row_total_sq_reg <= row_total_sq_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_area_sum_reg <= area_sum;
            m_area_sum_sq_reg <= area_sum_sq;
            m_row_end_reg <= s1_flags_reg.row_end;
            m_frame_end_reg <= s1_flags_reg.frame_end;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_area_sum = m_area_sum_reg;
    assign m_area_sum_sq = m_area_sum_sq_reg;
    assign m_row_end = m_row_end_reg;
    assign m_frame_end = m_frame_end_reg;

endmodule

[rtl/integral_image_with_squares_unit.sv]
// Streaming integral image with summed squares.
// Pixels enter in raster order as signed 16-bit transactions on the s_ channel.
// Each pixel yields one transaction on the m_ channel carrying the summed-area
// entry, the summed-area entry of squared pixels, and row-end and frame-end
// flags. The first row uses zero in place of the line store.
// An accepted pixel passes the stage-one registers and then the output register.
// One pixel is taken every cycle unless the receiver stalls; the line store is
// read on accept and written back on advance, bypassed if both touch one column.
// When the receiver stalls, the output register and the stage before it fill,
// after which s_ready falls; no transaction is lost.
// Frame width and height are written through cfg_we, cfg_index and cfg_wdata;
// zero is treated as one and values above the maximum saturate.
// Reset clears the counters, the row totals and the pipeline and restores a
// geometry of 2048 by 2048. The line store is not cleared; the first row never
// reads it.
module integral_image_with_squares_unit #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [iiws_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [iiws_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [iiws_pkg::PIX_W-1:0]   s_pixel,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [iiws_pkg::SUM_W-1:0]   m_area_sum,
    output logic [iiws_pkg::SUM_SQ_W-1:0]       m_area_sum_sq,
    output logic                                m_row_end,
    output logic                                m_frame_end
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic                        accept;
    logic [COL_W-1:0]            scan_col;
    iiws_pkg::scan_flags_t       scan_flags;
    logic                        line_wr_en;
    logic [COL_W-1:0]            line_wr_addr;
    logic [iiws_pkg::LINE_W-1:0] line_wr_data;
    logic [iiws_pkg::LINE_W-1:0] line_rd_data;

    assign accept = s_valid && s_ready;

    iiws_scan #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_scan (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .advance(accept),
        .col(scan_col),
        .flags(scan_flags)
    );

    iiws_ram #(
        .DATA_W(iiws_pkg::LINE_W),
        .DEPTH(MAX_WIDTH)
    ) u_line_store (
        .aclk(aclk),
        .wr_en(line_wr_en),
        .wr_addr(line_wr_addr),
        .wr_data(line_wr_data),
        .rd_en(accept),
        .rd_addr(scan_col),
        .rd_data(line_rd_data)
    );

    iiws_accum #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_accum (
        .aclk(aclk),
        .aresetn(aresetn),
        .in_accept(accept),
        .in_pixel(s_pixel),
        .in_col(scan_col),
        .in_flags(scan_flags),
        .in_ready(s_ready),
        .rd_data(line_rd_data),
        .wr_en(line_wr_en),
        .wr_addr(line_wr_addr),
        .wr_data(line_wr_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_area_sum(m_area_sum),
        .m_area_sum_sq(m_area_sum_sq),
        .m_row_end(m_row_end),
        .m_frame_end(m_frame_end)
    );

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_DIM = 2048;
    localparam int RANDOM_ITEMS = 1750;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 10;

    typedef enum {PIX_MIXED, PIX_MOST_NEG, PIX_MOST_POS} pixel_style_t;

    typedef struct {
        logic signed [iiws_pkg::SUM_W-1:0] area_sum;
        logic [iiws_pkg::SUM_SQ_W-1:0] area_sum_sq;
        logic row_end;
        logic frame_end;
    } sat_entry_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [iiws_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [iiws_pkg::CFG_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [iiws_pkg::PIX_W-1:0] s_pixel = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [iiws_pkg::SUM_W-1:0] m_area_sum;
    logic [iiws_pkg::SUM_SQ_W-1:0] m_area_sum_sq;
    logic m_row_end;
    logic m_frame_end;

    // Shadow copy of the block's geometry, counters, row totals and line store.
    logic [iiws_pkg::CFG_W-1:0] width_reg = iiws_pkg::FRAME_WIDTH_RESET;
    logic [iiws_pkg::CFG_W-1:0] height_reg = iiws_pkg::FRAME_HEIGHT_RESET;
    int col_cnt = 0;
    int row_cnt = 0;
    logic signed [26:0] row_sum = '0;
    logic [41:0] row_sum_sq = '0;
    logic signed [iiws_pkg::SUM_W-1:0] line_sums [MAX_DIM];
    logic [iiws_pkg::SUM_SQ_W-1:0] line_sums_sq [MAX_DIM];

    logic signed [iiws_pkg::PIX_W-1:0] pixel_backlog [$];
    sat_entry_t pending_entries [$];
    int pixels_queued = 0;
    int pixels_accepted = 0;
    int mismatches = 0;
    int stall_cycles = 0;
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;

    integral_image_with_squares_unit u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_pixel(s_pixel),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_area_sum(m_area_sum),
        .m_area_sum_sq(m_area_sum_sq),
        .m_row_end(m_row_end),
        .m_frame_end(m_frame_end)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic int clamp_dim(input logic [iiws_pkg::CFG_W-1:0] v);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > MAX_DIM) begin
            return MAX_DIM;
        end
        return int'(v);
    endfunction

    task automatic accumulate_pixel(input logic signed [iiws_pkg::PIX_W-1:0] pix);
        int w;
        int h;
        longint sq;
        logic signed [iiws_pkg::SUM_W-1:0] above;
        logic [iiws_pkg::SUM_SQ_W-1:0] above_sq;
        sat_entry_t e;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        if (col_cnt == 0) begin
            row_sum = '0;
            row_sum_sq = '0;
        end
        row_sum = row_sum + pix;
        sq = longint'(pix) * longint'(pix);
        row_sum_sq = row_sum_sq + sq[41:0];
        above = '0;
        above_sq = '0;
        if (row_cnt != 0) begin
            above = line_sums[col_cnt];
            above_sq = line_sums_sq[col_cnt];
        end
        e.area_sum = above + row_sum;
        e.area_sum_sq = above_sq + row_sum_sq;
        line_sums[col_cnt] = e.area_sum;
        line_sums_sq[col_cnt] = e.area_sum_sq;
        e.row_end = (col_cnt + 1 >= w);
        e.frame_end = e.row_end && (row_cnt + 1 >= h);
        pending_entries.push_back(e);
        if (e.row_end) begin
            col_cnt = 0;
            row_cnt = e.frame_end ? 0 : row_cnt + 1;
        end else begin
            col_cnt = col_cnt + 1;
        end
    endtask

    function automatic logic signed [iiws_pkg::PIX_W-1:0] make_pixel(
        input pixel_style_t style
    );
        int pick;
        if (style == PIX_MOST_NEG) begin
            return 16'sh8000;
        end
        if (style == PIX_MOST_POS) begin
            return 16'sh7FFF;
        end
        pick = $urandom_range(9);
        case (pick)
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return $urandom_range(1) ? 16'sh0000 : 16'shFFFF;
            3, 4: return iiws_pkg::PIX_W'($urandom_range(255));
            default: return iiws_pkg::PIX_W'($urandom);
        endcase
    endfunction

    task automatic queue_pixel(input logic signed [iiws_pkg::PIX_W-1:0] pix);
        pixel_backlog.push_back(pix);
        pixels_queued++;
    endtask

    task automatic wait_idle();
        do begin
            @(posedge aclk);
        end while (pixels_accepted != pixels_queued || pending_entries.size() != 0);
    endtask

    task automatic write_geometry(input logic [iiws_pkg::CFG_W-1:0] w,
                                  input logic [iiws_pkg::CFG_W-1:0] h);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= iiws_pkg::REG_FRAME_WIDTH;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_index <= iiws_pkg::REG_FRAME_HEIGHT;
        cfg_wdata <= h;
        @(posedge aclk);
        cfg_we <= 1'b0;
        width_reg = w;
        height_reg = h;
    endtask

    // The new geometry first completes whatever frame is in progress, then
    // runs whole frames and finally a partial one.
    task automatic run_phase(input logic [iiws_pkg::CFG_W-1:0] w_val,
                             input logic [iiws_pkg::CFG_W-1:0] h_val,
                             input int frames, input int extra, input pixel_style_t style);
        int w;
        int h;
        int lead;
        wait_idle();
        write_geometry(w_val, h_val);
        w = clamp_dim(w_val);
        h = clamp_dim(h_val);
        lead = 0;
        if (col_cnt != 0 || row_cnt != 0) begin
            lead = ((col_cnt < w) ? w - col_cnt : 1)
                 + ((row_cnt + 1 < h) ? (h - 1 - row_cnt) * w : 0);
        end
        repeat (lead + frames * w * h + extra) queue_pixel(make_pixel(style));
    endtask

    task automatic finish_frame();
        if (col_cnt != 0 || row_cnt != 0) begin
            run_phase(width_reg, height_reg, 0, 0, PIX_MIXED);
        end
    endtask

    task automatic set_idle_mode(input int progress);
        if (progress < RANDOM_ITEMS / 3) begin
            sender_idle_pct = 21;
            receiver_idle_pct = 60;
        end else if (progress < 2 * RANDOM_ITEMS / 3) begin
            sender_idle_pct = 60;
            receiver_idle_pct = 21;
        end else begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            set_idle_mode(pixels_accepted);
            if (s_valid && s_ready) begin
                accumulate_pixel(s_pixel);
                pixels_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pixel_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    s_valid <= 1'b1;
                    s_pixel <= pixel_backlog.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        sat_entry_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_entries.size() == 0) begin
                    $error("Result transaction arrived with no entry expected.");
                    mismatches++;
                end else begin
                    e = pending_entries.pop_front();
                    if (m_area_sum !== e.area_sum) begin
                        $error("area_sum: expected %0d, got %0d", e.area_sum, m_area_sum);
                        mismatches++;
                    end
                    if (m_area_sum_sq !== e.area_sum_sq) begin
                        $error("area_sum_sq: expected %0d, got %0d", e.area_sum_sq,
                               m_area_sum_sq);
                        mismatches++;
                    end
                    if (m_row_end !== e.row_end) begin
                        $error("row_end: expected %0b, got %0b", e.row_end, m_row_end);
                        mismatches++;
                    end
                    if (m_frame_end !== e.frame_end) begin
                        $error("frame_end: expected %0b, got %0b", e.frame_end, m_frame_end);
                        mismatches++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !aresetn) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        int w;
        int h;
        int frames;
        int extra;
        int random_base;
        bit wide_done;
        bit tall_done;
        logic [iiws_pkg::CFG_W-1:0] w_val;
        logic [iiws_pkg::CFG_W-1:0] h_val;
        pixel_style_t style;

        wide_done = 1'b0;
        tall_done = 1'b0;
        set_idle_mode(0);
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Extremes in the first row of the reset geometry.
        queue_pixel(16'sh7FFF);
        queue_pixel(16'sh8000);
        queue_pixel(16'sh0000);
        queue_pixel(16'shFFFF);
        queue_pixel(16'sh0001);
        queue_pixel(16'sh00FF);
        queue_pixel(16'sh0080);
        queue_pixel(16'sh8001);
        queue_pixel(16'sh5555);
        queue_pixel(16'shAAAA);
        queue_pixel(16'sh7FFF);
        queue_pixel(16'sh7FFF);
        queue_pixel(16'sh8000);
        queue_pixel(16'sh8000);
        queue_pixel(16'sh0000);
        queue_pixel(16'sh00FF);

        // Width shrinks below the running column, then height shrinks below
        // the running row; both must close the row or frame on the next pixel.
        run_phase(12'd3, 12'd2, 0, 0, PIX_MIXED);
        run_phase(12'd2, 12'd5, 0, 7, PIX_MIXED);
        run_phase(12'd2, 12'd2, 0, 0, PIX_MIXED);

        random_base = pixels_queued;
        while (pixels_queued - random_base < RANDOM_ITEMS) begin
            // A tall frame is left part-way so that the next geometry cuts it
            // short; one full row at the widest setting follows later.
            if (!tall_done && pixels_queued - random_base >= 100) begin
                finish_frame();
                run_phase(12'd0, 12'hFFF, 0, 64, PIX_MOST_NEG);
                tall_done = 1'b1;
            end else if (!wide_done && tall_done) begin
                finish_frame();
                run_phase(12'hFFF, 12'd0, 1, 0, PIX_MIXED);
                wide_done = 1'b1;
            end
            if (col_cnt != 0 || row_cnt != 0) begin
                w_val = iiws_pkg::CFG_W'($urandom_range(1, clamp_dim(width_reg)));
            end else begin
                w_val = iiws_pkg::CFG_W'($urandom_range(1, 24));
            end
            if ($urandom_range(9) == 0) begin
                w_val = '0;
            end
            h_val = ($urandom_range(9) == 0) ? '0 : iiws_pkg::CFG_W'($urandom_range(1, 8));
            w = clamp_dim(w_val);
            h = clamp_dim(h_val);
            extra = $urandom_range(1) ? $urandom_range(w * h - 1) : 0;
            frames = (extra != 0) ? $urandom_range(2) : $urandom_range(1, 3);
            if (w == MAX_DIM) begin
                frames = 1;
                extra = 0;
            end
            case ($urandom_range(9))
                0: style = PIX_MOST_NEG;
                1: style = PIX_MOST_POS;
                default: style = PIX_MIXED;
            endcase
            run_phase(w_val, h_val, frames, extra, style);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_entries.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
